// File: rtl/lfo_pkg.sv
// shared types, constants and the sine rom builder for the lfo generator
`timescale 1ns / 1ps

package lfo_pkg;

    // wave selector codes
    typedef enum logic [1:0]
    {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SQUARE = 2'd3
    } wave_t;

    // configuration register indexes
    localparam logic [1:0] CFG_WAVE   = 2'd0;
    localparam logic [1:0] CFG_CYCLES = 2'd1;
    localparam logic [1:0] CFG_AMP    = 2'd2;
    localparam logic [1:0] CFG_PHASE  = 2'd3;

    // register reset values
    localparam logic [15:0] CYCLES_RST = 16'd256;
    localparam logic [15:0] AMP_RST    = 16'hFFFF;
    localparam logic [15:0] PHASE_RST  = 16'd0;

    // table depth is a power of two; the angle fraction has 8 + log2 bits
    localparam int TABLE_DEPTH = 1024;
    localparam int TD_LOG2     = $clog2(TABLE_DEPTH);
    localparam int FRAC_W      = 8 + TD_LOG2;

    // field and product widths
    localparam int IDX_W  = 10;
    localparam int N_W    = IDX_W + 1;
    localparam int NUM_W  = 16 + N_W;
    localparam int LIN_W  = 32;
    localparam int PROD_W = LIN_W + 16;
    localparam int SMP_W  = 15;

    // default quarter-wave rom depth, a power of two
    localparam int SINE_ROM_DEPTH_DEF = 256;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // phase stage result handed to the rom stage
    typedef struct packed {
        logic              neg;
        logic [LIN_W-1:0]  lin;
    } ph_t;

    // one quarter-wave entry: q30 taylor sum through t^15, scaled to 15 bits
    function automatic logic [SMP_W-1:0] rom_entry(input logic [63:0] k,
                                                   input int aw);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] v;
        t    = (k * HALF_PI_Q30) >> aw;
        t2   = (t * t) >> 30;
        term = t;
        sum  = longint'(t);
        term = ((term * t2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * t2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * t2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage

// File: rtl/lfo_wave_table_generator_unit.sv
// lfo wave table generator: index in, one sine/saw/triangle/square sample out
// throughput: one request per cycle while m_tready is high
// the amplitude multiply and the rom read each own a stage
// each stage holds its request under back-pressure, so stalls drop or repeat nothing
// reset: valid flags clear; wave sine, cycles 1.0, amplitude full scale, phase zero
`timescale 1ns / 1ps

module lfo_wave_table_generator_unit #(
    parameter int SINE_ROM_DEPTH = lfo_pkg::SINE_ROM_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] sample_index, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample (signed q2.14)
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int ROM_AW = $clog2(SINE_ROM_DEPTH);

    lfo_pkg::wave_t            wave_type_reg;
    logic [15:0]               cycles_reg;
    logic [15:0]               amp_reg;
    logic [15:0]               phase_reg;
    logic [4:0]                vld_reg;
    logic [4:0]                vld_next;
    logic [4:0]                load;
    lfo_pkg::ph_t              ph2;
    lfo_pkg::ph_t              ph3;
    logic [ROM_AW:0]           k2;
    logic [lfo_pkg::SMP_W-1:0] s3;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg <= lfo_pkg::WAVE_SINE;
            cycles_reg    <= lfo_pkg::CYCLES_RST;
            amp_reg       <= lfo_pkg::AMP_RST;
            phase_reg     <= lfo_pkg::PHASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lfo_pkg::CFG_WAVE:   wave_type_reg <= lfo_pkg::wave_t'(cfg_wdata[1:0]);
                lfo_pkg::CFG_CYCLES: cycles_reg    <= cfg_wdata;
                lfo_pkg::CFG_AMP:    amp_reg       <= cfg_wdata;
                lfo_pkg::CFG_PHASE:  phase_reg     <= cfg_wdata;
                default:             phase_reg     <= phase_reg;
            endcase
        end
    end

    // stage load enables: a stage loads when empty or when the next one loads
    always_comb
    begin
        load[4] = ~vld_reg[4] | m_tready;
        load[3] = ~vld_reg[3] | load[4];
        load[2] = ~vld_reg[2] | load[3];
        load[1] = ~vld_reg[1] | load[2];
        load[0] = ~vld_reg[0] | load[1];
        vld_next[0] = load[0] ? s_tvalid   : vld_reg[0];
        vld_next[1] = load[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = load[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = load[3] ? vld_reg[2] : vld_reg[3];
        vld_next[4] = load[4] ? vld_reg[3] : vld_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // angle stages
    lfo_phase #(
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_phase (
        .clk    (clk),
        .load1  (load[0]),
        .load2  (load[1]),
        .idx    (s_tdata[lfo_pkg::IDX_W-1:0]),
        .wave   (wave_type_reg),
        .cycles (cycles_reg),
        .phase  (phase_reg),
        .ph     (ph2),
        .k      (k2)
    );

    // sine lookup stage
    lfo_rom #(
        .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
    ) u_rom (
        .clk    (clk),
        .load3  (load[2]),
        .k      (k2),
        .ph_in  (ph2),
        .s      (s3),
        .ph_out (ph3)
    );

    // scaling and output stages
    lfo_scale u_scale (
        .clk    (clk),
        .load4  (load[3]),
        .load5  (load[4]),
        .wave   (wave_type_reg),
        .amp    (amp_reg),
        .s      (s3),
        .ph     (ph3),
        .sample (m_tdata)
    );

    assign s_tready = load[0];
    assign m_tvalid = vld_reg[4];

endmodule

// File: rtl/lfo_phase.sv
// angle stages: index times cycles, then phase add, quadrant split and rom index
`timescale 1ns / 1ps

module lfo_phase #(
    parameter int SINE_ROM_DEPTH = lfo_pkg::SINE_ROM_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              load1,
    input  logic                              load2,
    input  logic [lfo_pkg::IDX_W-1:0]         idx,
    input  lfo_pkg::wave_t                    wave,
    input  logic [15:0]                       cycles,
    input  logic [15:0]                       phase,
    output lfo_pkg::ph_t                      ph,
    output logic [$clog2(SINE_ROM_DEPTH):0]   k
);

    localparam int ROM_AW = $clog2(SINE_ROM_DEPTH);

    logic [lfo_pkg::N_W-1:0]   n;
    logic [lfo_pkg::NUM_W-1:0] num_reg;
    logic [lfo_pkg::NUM_W-1:0] num_next;
    logic [31:0]               turn;
    logic [31:0]               poff;
    logic [31:0]               u;
    logic [29:0]               r;
    logic [30:0]               kr_sum;
    logic [ROM_AW:0]           k_raw;
    lfo_pkg::ph_t              ph_reg;
    lfo_pkg::ph_t              ph_next;
    logic [ROM_AW:0]           k_reg;
    logic [ROM_AW:0]           k_next;

    // square looks one position ahead
    always_comb
    begin
        n = {1'b0, idx};
        if (wave == lfo_pkg::WAVE_SQUARE)
        begin
            n = {1'b0, idx} + lfo_pkg::N_W'(1);
        end
        num_next = lfo_pkg::NUM_W'(cycles * n);
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            num_reg <= num_next;
        end
    end

    // fractional turn plus phase offset, wrapping at one turn
    always_comb
    begin
        turn = {num_reg[lfo_pkg::FRAC_W-1:0], {(32 - lfo_pkg::FRAC_W){1'b0}}};
        poff = {phase, 16'd0};
        if (wave == lfo_pkg::WAVE_SAW)
        begin
            poff = {phase[14:0], 17'd0};
        end
        u = turn + poff;
        r = u[29:0];
    end

    // sign and linear magnitude per wave
    always_comb
    begin
        ph_next.neg = u[31];
        ph_next.lin = 32'(r);
        case (wave)
            lfo_pkg::WAVE_SAW:
            begin
                ph_next.neg = ~u[31];
                if (u[31])
                begin
                    ph_next.lin = u - 32'h8000_0000;
                end
                else
                begin
                    ph_next.lin = 32'h8000_0000 - u;
                end
            end
            lfo_pkg::WAVE_SQUARE:
            begin
                ph_next.neg = u[31] & (|u[30:0]);
            end
            lfo_pkg::WAVE_TRI:
            begin
                if (u[30])
                begin
                    ph_next.lin = 32'h4000_0000 - 32'(r);
                end
            end
            default:
            begin
                ph_next.lin = 32'(r);
            end
        endcase
    end

    // rounded rom index, mirrored in odd quadrants
    always_comb
    begin
        kr_sum = {1'b0, r} + (31'd1 << (29 - ROM_AW));
        k_raw  = kr_sum[30 -: (ROM_AW + 1)];
        k_next = k_raw;
        if (u[30])
        begin
            k_next = (ROM_AW + 1)'(SINE_ROM_DEPTH) - k_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            ph_reg <= ph_next;
            k_reg  <= k_next;
        end
    end

    assign ph = ph_reg;
    assign k  = k_reg;

endmodule

// File: rtl/lfo_rom.sv
// quarter-wave sine rom with registered read
`timescale 1ns / 1ps

module lfo_rom #(
    parameter int SINE_ROM_DEPTH = lfo_pkg::SINE_ROM_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              load3,
    input  logic [$clog2(SINE_ROM_DEPTH):0]   k,
    input  lfo_pkg::ph_t                      ph_in,
    output logic [lfo_pkg::SMP_W-1:0]         s,
    output lfo_pkg::ph_t                      ph_out
);

    localparam int ROM_AW = $clog2(SINE_ROM_DEPTH);

    logic [lfo_pkg::SMP_W-1:0] rom_tab [0:SINE_ROM_DEPTH];
    logic [lfo_pkg::SMP_W-1:0] s_reg;
    lfo_pkg::ph_t              ph_reg;

    // constant table, built at elaboration
    for (genvar g = 0; g <= SINE_ROM_DEPTH; g++)
    begin : g_rom
        assign rom_tab[g] = lfo_pkg::rom_entry(64'(g), ROM_AW);
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s_reg  <= rom_tab[k];
            ph_reg <= ph_in;
        end
    end

    assign s      = s_reg;
    assign ph_out = ph_reg;

endmodule

// File: rtl/lfo_scale.sv
// amplitude multiply, per-wave rounding and sign
`timescale 1ns / 1ps

module lfo_scale (
    input  logic                       clk,
    input  logic                       load4,
    input  logic                       load5,
    input  lfo_pkg::wave_t             wave,
    input  logic [15:0]                amp,
    input  logic [lfo_pkg::SMP_W-1:0]  s,
    input  lfo_pkg::ph_t               ph,
    output logic [15:0]                sample
);

    logic [lfo_pkg::LIN_W-1:0]  op;
    logic [lfo_pkg::PROD_W-1:0] prod_reg;
    logic [lfo_pkg::PROD_W-1:0] prod_next;
    logic                       neg_reg;
    logic [lfo_pkg::PROD_W:0]   rsum;
    logic [15:0]                mag;
    logic [16:0]                sq;
    logic [15:0]                sample_reg;
    logic [15:0]                sample_next;

    // multiply stage
    always_comb
    begin
        op = ph.lin;
        if (wave == lfo_pkg::WAVE_SINE)
        begin
            op = lfo_pkg::LIN_W'(s);
        end
        prod_next = lfo_pkg::PROD_W'(op * amp);
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            prod_reg <= prod_next;
            neg_reg  <= ph.neg;
        end
    end

    // round half up per wave, then apply the sign
    always_comb
    begin
        sq   = ({1'b0, amp} + 17'd2) >> 2;
        rsum = '0;
        mag  = '0;
        case (wave)
            lfo_pkg::WAVE_SINE:
            begin
                rsum = {1'b0, prod_reg} + (49'd1 << 16);
                mag  = rsum[32:17];
            end
            lfo_pkg::WAVE_SAW:
            begin
                rsum = {1'b0, prod_reg} + (49'd1 << 32);
                mag  = rsum[48:33];
            end
            lfo_pkg::WAVE_TRI:
            begin
                rsum = {1'b0, prod_reg} + (49'd1 << 31);
                mag  = rsum[47:32];
            end
            lfo_pkg::WAVE_SQUARE:
            begin
                mag = sq[15:0];
            end
            default:
            begin
                mag = '0;
            end
        endcase
        sample_next = mag;
        if (neg_reg)
        begin
            sample_next = 16'd0 - mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load5)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule
